// ===== hw/rtl/kpc_pkg.sv =====
// Shared types, constants and register indexes of the key press classifier.
package kpc_pkg;

	// default shape
	localparam int DEF_N_KEYS    = 4;
	localparam int DEF_TIME_BITS = 16;

	// field and register widths
	localparam int LEVELS_W = 4;
	localparam int TICK_W   = 8;
	localparam int KCNT_W   = 3;
	localparam int MS_W     = 16;
	localparam int CLICK_W  = 8;
	localparam int KEY_W    = 2;
	localparam int TYPE_W   = 2;
	localparam int REG_IDX_W = 3;
	localparam int N_LONG   = 4;

	// register reset values
	localparam logic [TICK_W-1:0] DEF_TICK_MS    = 8'd20;
	localparam logic [KCNT_W-1:0] DEF_KEY_COUNT  = 3'd4;
	localparam logic [MS_W-1:0]   DEF_SEQ_GAP_MS = 16'd400;
	localparam logic [MS_W-1:0]   DEF_LONG_TIME  = 16'd3000;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_TICK_MS     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KEY_COUNT   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SEQ_GAP_MS  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_LONG_TIME_0 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LONG_TIME_1 = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_LONG_TIME_2 = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_LONG_TIME_3 = 3'd6;

	// press types
	localparam logic [TYPE_W-1:0] PT_NORMAL = 2'd0;
	localparam logic [TYPE_W-1:0] PT_LONG   = 2'd1;
	localparam logic [TYPE_W-1:0] PT_MULTI  = 2'd2;

	// key phases
	typedef enum logic [5:0] {
		PH_IDLE        = 6'b000001,
		PH_CONFIRM     = 6'b000010,
		PH_HELD        = 6'b000100,
		PH_REL_CONFIRM = 6'b001000,
		PH_RELEASED    = 6'b010000,
		PH_FINISHED    = 6'b100000
	} kpc_phase_t;

	// event found by one lane
	typedef struct packed {
		logic [TYPE_W-1:0]  press_type;
		logic [CLICK_W-1:0] clicks;
	} kpc_event_t;

endpackage

// ===== hw/rtl/key_press_classifier.sv =====
// Top level of the key press classifier: registers, key lanes and event merge.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: levels
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: key_index, click_count;
//                                              tuser: press_type; tlast: last
//  cfg       in   cfg_wen                      cfg_index, cfg_wdata
//
// All enabled lanes update together in the cycle an item is accepted, one lane per key.
// The merge stage then moves one event a cycle into the output register while the
// output is not stalled; each item produces at most N_KEYS events.
// The next item is taken once the last event has reached the output register.
// Reset puts every key in the idle phase and the registers at their defaults.
// A stalled output holds its event; pending events wait in the merge stage.
module key_press_classifier #(
	parameter int N_KEYS    = kpc_pkg::DEF_N_KEYS,
	parameter int TIME_BITS = kpc_pkg::DEF_TIME_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // [3:0] levels
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [15:0]                    m_axis_tdata,  // [1:0] key_index, [9:2] click_count
	output logic [kpc_pkg::TYPE_W-1:0]     m_axis_tuser,  // [1:0] press_type
	output logic                           m_axis_tlast,
	input  logic                           cfg_wen,
	input  logic [kpc_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [kpc_pkg::MS_W-1:0]       cfg_wdata
);
	import kpc_pkg::*;

	logic [TICK_W-1:0]   tick_ms_q;
	logic [KCNT_W-1:0]   key_count_q;
	logic [MS_W-1:0]     seq_gap_ms_q;
	logic [MS_W-1:0]     long_time_q [N_LONG];

	logic [LEVELS_W-1:0] levels;
	logic                accept;
	logic                idle;
	logic [N_KEYS-1:0]   fire;
	kpc_event_t          ev [N_KEYS];
	logic [KEY_W-1:0]    out_key;
	logic [CLICK_W-1:0]  out_clicks;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_ms_q    <= DEF_TICK_MS;
			key_count_q  <= DEF_KEY_COUNT;
			seq_gap_ms_q <= DEF_SEQ_GAP_MS;
			for (int i = 0; i < N_LONG; i++) long_time_q[i] <= DEF_LONG_TIME;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_TICK_MS:     tick_ms_q      <= cfg_wdata[TICK_W-1:0];
				REG_KEY_COUNT:   key_count_q    <= cfg_wdata[KCNT_W-1:0];
				REG_SEQ_GAP_MS:  seq_gap_ms_q   <= cfg_wdata;
				REG_LONG_TIME_0: long_time_q[0] <= cfg_wdata;
				REG_LONG_TIME_1: long_time_q[1] <= cfg_wdata;
				REG_LONG_TIME_2: long_time_q[2] <= cfg_wdata;
				REG_LONG_TIME_3: long_time_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign levels        = s_axis_tdata[LEVELS_W-1:0];
	assign s_axis_tready = idle;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// one lane per key
	for (genvar k = 0; k < N_KEYS; k++) begin : g_lane
		logic            pressed;
		logic            enable;
		logic [MS_W-1:0] thr;

		if (k < LEVELS_W) begin : g_wired
			assign pressed = !levels[k];
		end else begin : g_unwired
			assign pressed = 1'b0;
		end

		if (k < N_LONG) begin : g_thr
			assign thr = long_time_q[k];
		end else begin : g_no_thr
			assign thr = '0;
		end

		assign enable = 5'(k) < 5'(key_count_q);

		kpc_lane #(
			.TIME_BITS (TIME_BITS)
		) u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.accept     (accept),
			.enable     (enable),
			.pressed    (pressed),
			.tick_ms    (tick_ms_q),
			.seq_gap_ms (seq_gap_ms_q),
			.long_time  (thr),
			.fire       (fire[k]),
			.ev         (ev[k])
		);
	end

	// serialise events in key order
	kpc_merge #(
		.N_KEYS (N_KEYS)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept),
		.fire       (fire),
		.ev         (ev),
		.idle       (idle),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_key    (out_key),
		.out_type   (m_axis_tuser),
		.out_clicks (out_clicks),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {6'd0, out_clicks, out_key};

endmodule

// ===== hw/rtl/kpc_lane.sv =====
// One key lane: debounce phases, hold and release timing, click counting.
module kpc_lane #(
	parameter int TIME_BITS = kpc_pkg::DEF_TIME_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic                        enable,
	input  logic                        pressed,
	input  logic [kpc_pkg::TICK_W-1:0]  tick_ms,
	input  logic [kpc_pkg::MS_W-1:0]    seq_gap_ms,
	input  logic [kpc_pkg::MS_W-1:0]    long_time,
	output logic                        fire,
	output kpc_pkg::kpc_event_t         ev
);
	import kpc_pkg::*;

	localparam int TW = TIME_BITS;
	localparam int SW = TIME_BITS + 2;
	localparam int CW = (TIME_BITS > MS_W) ? TIME_BITS : MS_W;
	localparam logic [TW-1:0] TMAX = {TW{1'b1}};

	function automatic logic [TW-1:0] sat(input logic [SW-1:0] s);
		return (s > SW'(TMAX)) ? TMAX : s[TW-1:0];
	endfunction

	kpc_phase_t         phase_q, phase_d;
	logic [TW-1:0]      hold_q, hold_d;
	logic [TW-1:0]      rel_q, rel_d;
	logic [CLICK_W-1:0] clicks_q, clicks_d;
	kpc_event_t         ev_q;

	logic [SW-1:0]      tick_x, tick2;
	logic [TW-1:0]      hold_cnt, hold_rc, rel_cnt;
	logic [CLICK_W-1:0] clicks_inc;
	logic               rel_done, rel_cnt_done, is_long;

	// time and click arithmetic
	assign tick_x     = SW'(tick_ms);
	assign tick2      = SW'({tick_ms, 1'b0});
	assign hold_cnt   = sat(SW'(hold_q) + ((hold_q == '0) ? tick2 : tick_x));
	assign hold_rc    = sat(SW'(hold_q) + tick2);
	assign rel_cnt    = sat(SW'(rel_q) + ((rel_q == '0) ? tick2 : tick_x));
	assign clicks_inc = (clicks_q == {CLICK_W{1'b1}}) ? clicks_q : clicks_q + 1'b1;
	assign rel_done     = CW'(rel_q) >= CW'(seq_gap_ms);
	assign rel_cnt_done = CW'(rel_cnt) >= CW'(seq_gap_ms);
	assign is_long      = CW'(hold_q) >= CW'(long_time);

	// next phase and counters
	always_comb begin
		phase_d  = phase_q;
		hold_d   = hold_q;
		rel_d    = rel_q;
		clicks_d = clicks_q;
		case (phase_q)
			PH_IDLE: begin
				if (pressed) phase_d = PH_CONFIRM;
				hold_d   = '0;
				rel_d    = '0;
				clicks_d = '0;
			end
			PH_CONFIRM: begin
				if (pressed) begin
					phase_d = PH_HELD;
				end else begin
					phase_d = PH_IDLE;
					hold_d  = '0;
				end
			end
			PH_HELD: begin
				if (pressed) begin
					hold_d = hold_cnt;
				end else begin
					phase_d = PH_REL_CONFIRM;
					rel_d   = '0;
				end
			end
			PH_REL_CONFIRM: begin
				if (!pressed) begin
					phase_d = PH_RELEASED;
				end else begin
					hold_d  = hold_rc;
					phase_d = PH_HELD;
				end
			end
			PH_RELEASED: begin
				if (!pressed) begin
					rel_d = rel_cnt;
					if (rel_cnt_done) begin
						phase_d = PH_FINISHED;
						if (clicks_q != '0) clicks_d = clicks_inc;
					end
				end else if (rel_done) begin
					phase_d = PH_FINISHED;
					if (clicks_q != '0) clicks_d = clicks_inc;
				end else begin
					phase_d  = PH_CONFIRM;
					rel_d    = '0;
					clicks_d = clicks_inc;
				end
			end
			PH_FINISHED: begin
				phase_d = PH_IDLE;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	assign fire = accept && enable && (phase_q == PH_FINISHED);

	// advance the key state on each enabled item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			hold_q   <= '0;
			rel_q    <= '0;
			clicks_q <= '0;
		end else if (accept && enable) begin
			phase_q  <= phase_d;
			hold_q   <= hold_d;
			rel_q    <= rel_d;
			clicks_q <= clicks_d;
		end
	end

	// hold the classified event for the merge stage
	always_ff @(posedge clk) begin
		if (fire) begin
			ev_q.clicks     <= clicks_q;
			ev_q.press_type <= (clicks_q != '0) ? PT_MULTI : (is_long ? PT_LONG : PT_NORMAL);
		end
	end

	assign ev = ev_q;

endmodule

// ===== hw/rtl/kpc_merge.sv =====
// Merge stage: emits the events found by the lanes in rising key order.
module kpc_merge #(
	parameter int N_KEYS = kpc_pkg::DEF_N_KEYS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [N_KEYS-1:0]             fire,
	input  kpc_pkg::kpc_event_t           ev [N_KEYS],
	output logic                          idle,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [kpc_pkg::KEY_W-1:0]     out_key,
	output logic [kpc_pkg::TYPE_W-1:0]    out_type,
	output logic [kpc_pkg::CLICK_W-1:0]   out_clicks,
	output logic                          out_last
);
	import kpc_pkg::*;

	logic [N_KEYS-1:0]  pend_q;
	logic [N_KEYS-1:0]  sel;
	logic               take;
	logic [KEY_W-1:0]   sel_key;
	kpc_event_t         sel_ev;
	logic               sel_last;

	logic               out_valid_q, out_last_q;
	logic [KEY_W-1:0]   out_key_q;
	logic [TYPE_W-1:0]  out_type_q;
	logic [CLICK_W-1:0] out_clicks_q;

	// pick the lowest pending key
	assign sel      = pend_q & (~pend_q + 1'b1);
	assign sel_last = (pend_q & ~sel) == '0;
	assign take     = (pend_q != '0) && (!out_valid_q || out_ready);

	always_comb begin
		sel_key = '0;
		sel_ev  = '0;
		for (int i = 0; i < N_KEYS; i++) begin
			if (sel[i]) begin
				sel_key = KEY_W'(i);
				sel_ev  = ev[i];
			end
		end
	end

	// load new events, drop each as it moves out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			pend_q <= fire;
		end else if (take) begin
			pend_q <= pend_q & ~sel;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_key_q    <= sel_key;
			out_type_q   <= sel_ev.press_type;
			out_clicks_q <= sel_ev.clicks;
			out_last_q   <= sel_last;
		end
	end

	assign idle       = pend_q == '0;
	assign out_valid  = out_valid_q;
	assign out_key    = out_key_q;
	assign out_type   = out_type_q;
	assign out_clicks = out_clicks_q;
	assign out_last   = out_last_q;

	// a new item only arrives once every event of the last one has moved to the output register
	a_load_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> pend_q == '0)
		else $error("events loaded while earlier events pending");

	// each move to the output register retires exactly one pending event
	a_one_per_take: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !load) |=> $countones(pend_q) == $countones($past(pend_q)) - 1)
		else $error("pending mask did not drop one event");

	// the event marked last leaves nothing behind
	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(take && sel_last && !load) |=> pend_q == '0)
		else $error("events left after last event");

endmodule

// ===== dv/key_press_classifier_tb.sv =====
// Self-checking testbench of the key press classifier: stimulus, key model and event checks.
`timescale 1ns / 1ps

module key_press_classifier_tb;
	import kpc_pkg::*;

	localparam int N_KEYS        = DEF_N_KEYS;
	localparam int SETTLE_CYCLES = N_KEYS + 4;
	localparam int STALL_LIMIT   = 4000;
	localparam int MAX_REPORTS   = 10;

	// register index outside the list, written to check that it is ignored
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum logic [1:0] {RX_FLOW, RX_CHOPPY, RX_HOLD} rx_mode_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [TYPE_W-1:0]  kind;
		logic [CLICK_W-1:0] clicks;
		logic               last;
	} key_event_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata = '0;   // [3:0] levels
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [15:0]          m_axis_tdata;        // [1:0] key_index, [9:2] click_count
	logic [TYPE_W-1:0]    m_axis_tuser;        // [1:0] press_type
	logic                 m_axis_tlast;
	logic                 cfg_wen = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [MS_W-1:0]      cfg_wdata = '0;

	key_press_classifier dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #2 clk = ~clk;

	// model copy of the registers
	logic [TICK_W-1:0] cur_tick;
	logic [KCNT_W-1:0] cur_keys;
	logic [MS_W-1:0]   cur_gap;
	logic [MS_W-1:0]   cur_long [N_LONG];

	// model copy of the per-key state
	kpc_phase_t        ph          [N_KEYS];
	logic [MS_W-1:0]   held_ms     [N_KEYS];
	logic [MS_W-1:0]   gap_run_ms  [N_KEYS];
	logic [CLICK_W-1:0] click_tally [N_KEYS];

	key_event_t pending_events [$];
	int         mismatches = 0;
	int         burst_left = 0;

	// saturating add at the time width
	function automatic logic [MS_W-1:0] ms_add(input logic [MS_W-1:0] a,
			input logic [MS_W-1:0] b);
		logic [MS_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[MS_W] ? {MS_W{1'b1}} : s[MS_W-1:0];
	endfunction

	// first counted tick adds twice the tick, later ones add one tick
	function automatic logic [MS_W-1:0] grow_ms(input logic [MS_W-1:0] t);
		if (t == '0)
			return ms_add('0, {7'b0, cur_tick, 1'b0});
		return ms_add(t, {8'b0, cur_tick});
	endfunction

	function automatic logic [CLICK_W-1:0] bump_clicks(input logic [CLICK_W-1:0] c);
		return (c == {CLICK_W{1'b1}}) ? c : c + 1'b1;
	endfunction

	// advance every enabled key by one tick and queue the events it reports
	function automatic void classify_tick(input logic [LEVELS_W-1:0] lv);
		key_event_t evs [N_KEYS];
		int         n_ev;
		int         n_act;
		logic       pressed;
		n_ev = 0;
		n_act = (int'(cur_keys) > N_KEYS) ? N_KEYS : int'(cur_keys);
		for (int k = 0; k < n_act; k++) begin
			pressed = !lv[k];
			case (ph[k])
				PH_IDLE: begin
					if (pressed)
						ph[k] = PH_CONFIRM;
					held_ms[k] = '0;
					gap_run_ms[k] = '0;
					click_tally[k] = '0;
				end
				PH_CONFIRM: begin
					if (pressed) begin
						ph[k] = PH_HELD;
					end else begin
						ph[k] = PH_IDLE;
						held_ms[k] = '0;
					end
				end
				PH_HELD: begin
					if (pressed) begin
						held_ms[k] = grow_ms(held_ms[k]);
					end else begin
						ph[k] = PH_REL_CONFIRM;
						gap_run_ms[k] = '0;
					end
				end
				PH_REL_CONFIRM: begin
					if (!pressed) begin
						ph[k] = PH_RELEASED;
					end else begin
						// bounce: back to held, crediting the two ticks
						held_ms[k] = ms_add(held_ms[k], {7'b0, cur_tick, 1'b0});
						ph[k] = PH_HELD;
					end
				end
				PH_RELEASED: begin
					if (!pressed) begin
						gap_run_ms[k] = grow_ms(gap_run_ms[k]);
						if (gap_run_ms[k] >= cur_gap)
							ph[k] = PH_FINISHED;
					end else if (gap_run_ms[k] >= cur_gap) begin
						ph[k] = PH_FINISHED;
					end else begin
						ph[k] = PH_CONFIRM;
						gap_run_ms[k] = '0;
						click_tally[k] = bump_clicks(click_tally[k]);
					end
					if (ph[k] == PH_FINISHED && click_tally[k] != '0)
						click_tally[k] = bump_clicks(click_tally[k]);
				end
				PH_FINISHED: begin
					evs[n_ev].key = KEY_W'(k);
					if (click_tally[k] != '0)
						evs[n_ev].kind = PT_MULTI;
					else if (held_ms[k] >= cur_long[k])
						evs[n_ev].kind = PT_LONG;
					else
						evs[n_ev].kind = PT_NORMAL;
					evs[n_ev].clicks = click_tally[k];
					evs[n_ev].last = 1'b0;
					n_ev++;
					ph[k] = PH_IDLE;
				end
				default: ;
			endcase
		end
		if (n_ev > 0)
			evs[n_ev-1].last = 1'b1;
		for (int i = 0; i < n_ev; i++)
			pending_events.push_back(evs[i]);
	endfunction

	// track register writes, predict on each accepted item, check each event
	always @(posedge clk) begin : monitor
		key_event_t want;
		key_event_t got;
		if (arst_n) begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_TICK_MS:     cur_tick = cfg_wdata[TICK_W-1:0];
					REG_KEY_COUNT:   cur_keys = cfg_wdata[KCNT_W-1:0];
					REG_SEQ_GAP_MS:  cur_gap = cfg_wdata;
					REG_LONG_TIME_0: cur_long[0] = cfg_wdata;
					REG_LONG_TIME_1: cur_long[1] = cfg_wdata;
					REG_LONG_TIME_2: cur_long[2] = cfg_wdata;
					REG_LONG_TIME_3: cur_long[3] = cfg_wdata;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				classify_tick(s_axis_tdata[LEVELS_W-1:0]);
			if (m_axis_tvalid && m_axis_tready) begin
				got.key = m_axis_tdata[1:0];
				got.kind = m_axis_tuser;
				got.clicks = m_axis_tdata[9:2];
				got.last = m_axis_tlast;
				if (pending_events.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected event: key %0d type %0d clicks %0d last %0b",
							got.key, got.kind, got.clicks, got.last);
				end else begin
					want = pending_events.pop_front();
					if (got != want) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("mismatch: want k%0d t%0d c%0d l%0b got k%0d t%0d c%0d l%0b",
								want.key, want.kind, want.clicks, want.last,
								got.key, got.kind, got.clicks, got.last);
					end
				end
			end
		end
	end

	// receiver: free flow, choppy and stalled stretches
	rx_mode_t rx_mode = RX_FLOW;
	int       rx_left = 0;

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 10) : $urandom_range(1, 24);
		end
		rx_left--;
		case (rx_mode)
			RX_FLOW:   m_axis_tready <= 1'b1;
			RX_CHOPPY: m_axis_tready <= ($urandom_range(0, 2) != 0);
			default:   m_axis_tready <= 1'b0;
		endcase
	end

	// watchdog: end the run when nothing moves for too long
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wen)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// present one tick item, in bursts with random gaps, and wait for its acceptance
	task automatic send_tick(input logic [LEVELS_W-1:0] lv);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = $urandom_range(0, 8);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(8-LEVELS_W){1'b0}}, lv};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		burst_left--;
	endtask

	task automatic hold_levels(input logic [LEVELS_W-1:0] lv, input int n);
		repeat (n) send_tick(lv);
	endtask

	// stop sending, let the last item reach the model, drain every expected event
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write every register once the block is idle; unused upper bits carry noise
	task automatic apply_setting(input logic [TICK_W-1:0] tick, input logic [KCNT_W-1:0] kc,
			input logic [MS_W-1:0] gap, input logic [MS_W-1:0] l0, input logic [MS_W-1:0] l1,
			input logic [MS_W-1:0] l2, input logic [MS_W-1:0] l3);
		logic [REG_IDX_W-1:0] idx [8];
		logic [MS_W-1:0]      val [8];
		logic [MS_W-1:0]      noise;
		noise = MS_W'($urandom);
		idx = '{REG_TICK_MS, REG_KEY_COUNT, REG_SEQ_GAP_MS, REG_LONG_TIME_0,
			REG_LONG_TIME_1, REG_LONG_TIME_2, REG_LONG_TIME_3, REG_UNUSED};
		val = '{{noise[15:8], tick}, {noise[12:0], kc}, gap, l0, l1, l2, l3, noise};
		settle();
		for (int i = 0; i < 8; i++) begin
			cfg_wen <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= val[i];
			@(posedge clk);
		end
		cfg_wen <= 1'b0;
	endtask

	// reset values: a short press on key 0, a one-tick glitch on key 1
	task automatic test_defaults();
		send_tick(4'b1100);
		hold_levels(4'b1110, 2);
		hold_levels(4'b1111, 22);
	endtask

	// normal and long presses against per-key thresholds, plus a release bounce
	task automatic test_press_types();
		apply_setting(8'd20, 3'd4, 16'd60, 16'd0, 16'd40, 16'hFFFF, 16'd100);
		hold_levels(4'b0000, 4);
		hold_levels(4'b1111, 6);
		hold_levels(4'b0000, 3);
		send_tick(4'b1111);
		send_tick(4'b0000);
		hold_levels(4'b1111, 6);
	endtask

	// re-presses inside the gap, with keys 1 and 3 sitting out the second round
	task automatic test_multi_click();
		apply_setting(8'd20, 3'd4, 16'd60, 16'd3000, 16'd3000, 16'd3000, 16'd3000);
		for (int r = 0; r < 3; r++) begin
			hold_levels((r == 1) ? 4'b1010 : 4'b0000, 2);
			hold_levels(4'b1111, 2);
		end
		hold_levels(4'b1111, 5);
	endtask

	// no keys, too many keys, then one key
	task automatic test_key_count();
		apply_setting(8'd20, 3'd0, 16'd40, 16'd60, 16'd60, 16'd60, 16'd60);
		hold_levels(4'b0000, 3);
		hold_levels(4'b1111, 3);
		apply_setting(8'd20, 3'd6, 16'd40, 16'd60, 16'd60, 16'd60, 16'd60);
		hold_levels(4'b0101, 3);
		hold_levels(4'b1111, 5);
		apply_setting(8'd20, 3'd1, 16'd40, 16'd60, 16'd60, 16'd60, 16'd60);
		hold_levels(4'b0000, 3);
		hold_levels(4'b1111, 5);
	endtask

	// zero tick with zero gap, then the widest tick until the hold times saturate
	task automatic test_tick_extremes();
		apply_setting(8'd0, 3'd4, 16'd0, 16'd0, 16'd1, 16'd2, 16'd3);
		hold_levels(4'b0000, 3);
		hold_levels(4'b1111, 3);
		apply_setting(8'd255, 3'd4, 16'd600, 16'hFFFF, 16'hFFFE, 16'd0, 16'hFFFF);
		// keys 0 and 1 stay down past saturation while keys 2 and 3 chatter
		repeat (259) send_tick({2'($urandom_range(0, 3)), 2'b00});
		hold_levels(4'b1111, 6);
	endtask

	initial begin
		// model state and registers at their reset values
		cur_tick = DEF_TICK_MS;
		cur_keys = DEF_KEY_COUNT;
		cur_gap = DEF_SEQ_GAP_MS;
		for (int i = 0; i < N_LONG; i++)
			cur_long[i] = DEF_LONG_TIME;
		for (int k = 0; k < N_KEYS; k++) begin
			ph[k] = PH_IDLE;
			held_ms[k] = '0;
			gap_run_ms[k] = '0;
			click_tally[k] = '0;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_defaults();
		test_press_types();
		test_multi_click();
		test_key_count();
		test_tick_extremes();
		settle();

		if (mismatches == 0 && pending_events.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
